// ===== hw/rtl/hole_fill_dilation_unit_assert.svh =====
// Assertion macros for the hole fill dilation unit.
// Used by the port checker; depends on nothing else.
`ifndef HOLE_FILL_DILATION_UNIT_ASSERT_SVH
`define HOLE_FILL_DILATION_UNIT_ASSERT_SVH

// same-cycle implication
`define HFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("hfd assertion failed");

// next-cycle implication
`define HFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("hfd assertion failed");

`endif

// ===== hw/rtl/hfd_pkg.sv =====
// Shared types and constants of the hole fill dilation unit.
// No dependencies; imported by every module of the block.
package hfd_pkg;

	localparam int PIX_BITS     = 16;
	localparam int IMG_W_BITS   = 13;
	localparam int ROW_BITS     = 16;
	localparam int OUT_COL_BITS = 12;
	localparam int CFG_BITS     = 16;

	localparam logic [IMG_W_BITS-1:0] IMAGE_WIDTH_RESET  = 13'd1024;
	localparam logic [ROW_BITS-1:0]   IMAGE_HEIGHT_RESET = 16'd1024;

	localparam logic CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic                operation;
		logic [PIX_BITS-1:0] in_red;
		logic [PIX_BITS-1:0] in_green;
		logic [PIX_BITS-1:0] in_blue;
		logic [PIX_BITS-1:0] in_alpha;
	} in_req_t;

	typedef struct packed {
		logic [PIX_BITS-1:0]     out_red;
		logic [PIX_BITS-1:0]     out_green;
		logic [PIX_BITS-1:0]     out_blue;
		logic [PIX_BITS-1:0]     out_alpha;
		logic [OUT_COL_BITS-1:0] out_column;
		logic [ROW_BITS-1:0]     out_row;
		logic                    frame_last;
	} out_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_FETCH,
		ST_SELECT,
		ST_DIVIDE,
		ST_PUT
	} hfd_state_t;

endpackage

// ===== hw/rtl/hole_fill_dilation_unit.sv =====
// Hole fill dilation unit: fills empty RGBA pixels of a raster stream.
// Depends on hfd_pkg, hfd_line_store and hfd_div_cell.
//
// Input channel: in_valid/in_ready/in_data, one request per pixel in raster
// order, or a drain request (operation = OP_DRAIN) that stores nothing and
// only lets a pending result out. Output channel: out_valid/out_ready/
// out_data, at most one result per input request, frame_last on the last
// pixel of the frame. Configuration: cfg_write/cfg_index/cfg_data write
// image_width (index 0) or image_height (index 1); a write restarts the frame.
// One request is worked at a time. For a request that yields a result, the
// neighbor fetch is serial through the single read port of the line store,
// and a filled hole then also passes through the divider chain.
// A result sits in the output register until taken; the next request is
// accepted meanwhile, and the block stalls before its own result only while
// the previous one is still waiting. Reset clears positions and control and
// loads both size registers with 1024; the line store is not cleared.
module hole_fill_dilation_unit #(
	parameter int MAX_WIDTH    = 4096,
	parameter int CHANNEL_BITS = 16,
	parameter int REACH        = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  hfd_pkg::in_req_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output hfd_pkg::out_req_t out_data,
	input  logic             cfg_write,
	input  logic             cfg_index,
	input  logic [hfd_pkg::CFG_BITS-1:0] cfg_data
);
	import hfd_pkg::*;

	localparam int SLOTS  = 2 * REACH + 2;
	localparam int NTAPS  = 4 * REACH * REACH;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int W_W    = $clog2(MAX_WIDTH + 1);
	localparam int DEPTH  = SLOTS * MAX_WIDTH;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int PIX_W  = 4 * CHANNEL_BITS;
	localparam int CNT_W  = $clog2(NTAPS + 1);
	localparam int SUM_W  = CHANNEL_BITS + CNT_W;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int TAP_W  = $clog2(NTAPS + 2);
	localparam int IDX_W  = $clog2(2 * REACH);
	localparam int OFF_W  = $clog2(REACH + 1) + 1;
	localparam int DCNT_W = $clog2(SUM_W);
	localparam int CMP_W  = (W_W > IMG_W_BITS) ? W_W : IMG_W_BITS;
	localparam int XS_W   = COL_W + 2;
	localparam int YS_W   = ROW_BITS + 2;
	localparam int SS_W   = SLOT_W + 2;

	hfd_state_t state_q, state_n;

	logic [IMG_W_BITS-1:0] image_width_q;
	logic [ROW_BITS-1:0]   image_height_q;
	logic [COL_W-1:0]      in_col_q, out_col_q;
	logic [ROW_BITS-1:0]   in_row_q, out_row_q;
	logic [SLOT_W-1:0]     in_slot_q, out_slot_q;
	logic                  frame_full_q;

	logic [W_W-1:0]      w_eff;
	logic [COL_W-1:0]    w_m1;
	logic [ROW_BITS-1:0] h_eff, h_m1;

	logic                accept, store_px, issue, div_en, put_fire, out_rdy;
	logic                out_valid_q;
	out_req_t            out_data_q;

	// size registers and effective sizes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RESET;
			image_height_q <= IMAGE_HEIGHT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data[IMG_W_BITS-1:0];
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[ROW_BITS-1:0];
				default:          image_width_q  <= image_width_q;
			endcase
		end
	end

	always_comb begin
		if (image_width_q == '0) begin
			w_eff = W_W'(1);
		end else if (CMP_W'(image_width_q) > CMP_W'(MAX_WIDTH)) begin
			w_eff = W_W'(MAX_WIDTH);
		end else begin
			w_eff = W_W'(image_width_q);
		end
		w_m1  = COL_W'(w_eff - W_W'(1));
		h_eff = (image_height_q == '0) ? ROW_BITS'(1) : image_height_q;
		h_m1  = h_eff - ROW_BITS'(1);
	end

	// input side: store a pixel
	logic [PIX_W-1:0]  wr_pix;
	logic [3:0][31:0]  in_ext;
	logic [ADDR_W-1:0] wr_addr;

	always_comb begin
		in_ext[0] = 32'(in_data.in_red);
		in_ext[1] = 32'(in_data.in_green);
		in_ext[2] = 32'(in_data.in_blue);
		in_ext[3] = 32'(in_data.in_alpha);
		for (int k = 0; k < 4; k++) begin
			wr_pix[k*CHANNEL_BITS +: CHANNEL_BITS] = in_ext[k][CHANNEL_BITS-1:0];
		end
		wr_addr = ADDR_W'(in_slot_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_q);
	end

	assign accept   = in_valid && in_ready;
	assign store_px = accept && (in_data.operation == OP_PIXEL) && !frame_full_q;

	// neighbor fetch sequencing
	logic [TAP_W-1:0]         tap_q;
	logic [IDX_W-1:0]         dxi_q, dyi_q;
	logic signed [OFF_W-1:0]  dx_s, dy_s, dy_eff;
	logic signed [XS_W-1:0]   xs;
	logic signed [YS_W-1:0]   ys, cy_s;
	logic signed [SS_W-1:0]   st;
	logic [COL_W-1:0]         cx;
	logic [SLOT_W-1:0]        rd_slot;
	logic [ADDR_W-1:0]        rd_addr;

	always_comb begin
		if (tap_q == '0) begin
			dx_s = '0;
			dy_s = '0;
		end else begin
			dx_s = (dxi_q < IDX_W'(REACH)) ? signed'(OFF_W'(dxi_q) - OFF_W'(REACH))
				: signed'(OFF_W'(dxi_q) - OFF_W'(REACH - 1));
			dy_s = (dyi_q < IDX_W'(REACH)) ? signed'(OFF_W'(dyi_q) - OFF_W'(REACH))
				: signed'(OFF_W'(dyi_q) - OFF_W'(REACH - 1));
		end
		xs = $signed({2'b00, out_col_q}) + XS_W'(dx_s);
		if (xs < 0) begin
			cx = '0;
		end else if (xs > $signed({2'b00, w_m1})) begin
			cx = w_m1;
		end else begin
			cx = xs[COL_W-1:0];
		end
		ys = $signed({2'b00, out_row_q}) + YS_W'(dy_s);
		if (ys < 0) begin
			cy_s = '0;
		end else if (ys > $signed({2'b00, h_m1})) begin
			cy_s = $signed({2'b00, h_m1});
		end else begin
			cy_s = ys;
		end
		dy_eff = OFF_W'(cy_s - $signed({2'b00, out_row_q}));
		st = $signed({2'b00, out_slot_q}) + SS_W'(dy_eff);
		if (st < 0) begin
			st = st + SS_W'(SLOTS);
		end else if (st >= $signed(SS_W'(SLOTS))) begin
			st = st - SS_W'(SLOTS);
		end
		rd_slot = st[SLOT_W-1:0];
		rd_addr = ADDR_W'(rd_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cx);
	end

	// readiness of the next result
	logic [ROW_BITS:0] nr, nr_raw;
	logic [XS_W-1:0]   nc, nc_raw;

	always_comb begin
		nr_raw  = {1'b0, out_row_q} + (ROW_BITS + 1)'(REACH);
		nr      = (nr_raw > {1'b0, h_m1}) ? {1'b0, h_m1} : nr_raw;
		nc_raw  = XS_W'(out_col_q) + XS_W'(REACH);
		nc      = (nc_raw > XS_W'(w_m1)) ? XS_W'(w_m1) : nc_raw;
		out_rdy = frame_full_q || ({1'b0, in_row_q} > nr)
			|| (({1'b0, in_row_q} == nr) && (XS_W'(in_col_q) > nc));
	end

	// memory
	logic              valid_s1, center_s1, last_s1;
	logic              valid_s2, center_s2, last_s2;
	logic [ADDR_W-1:0] addr_s1;
	logic [PIX_W-1:0]  rdata_s2;

	hfd_line_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (PIX_W)
	) u_line_store (
		.clk     (clk),
		.wr_en   (store_px),
		.wr_addr (wr_addr),
		.wr_data (wr_pix),
		.rd_en   (valid_s1),
		.rd_addr (addr_s1),
		.rd_data (rdata_s2)
	);

	// accumulation
	logic [PIX_W-1:0]            center_q;
	logic [3:0][SUM_W-1:0]       sum_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        use_div_q;
	logic [DCNT_W-1:0]           div_cnt_q;
	logic                        center_set, skip_div;

	assign center_set = |center_q;
	assign skip_div   = center_set || (cnt_q == '0);

	// divider chain
	logic [SUM_W:0][3:0][SUM_W-1:0] ch_dvd, ch_quo;
	logic [SUM_W:0][3:0][CNT_W-1:0] ch_rem;
	logic [SUM_W:0][CNT_W-1:0]      ch_div;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			ch_dvd[0][k] = sum_q[k] + SUM_W'(cnt_q >> 1);
		end
		ch_quo[0] = '0;
		ch_rem[0] = '0;
		ch_div[0] = cnt_q;
	end

	for (genvar c = 0; c < SUM_W; c++) begin : g_cell
		hfd_div_cell #(
			.SUM_W (SUM_W),
			.CNT_W (CNT_W)
		) u_cell (
			.clk   (clk),
			.en    (div_en),
			.dvd_i (ch_dvd[c]),
			.quo_i (ch_quo[c]),
			.rem_i (ch_rem[c]),
			.div_i (ch_div[c]),
			.dvd_o (ch_dvd[c+1]),
			.quo_o (ch_quo[c+1]),
			.rem_o (ch_rem[c+1]),
			.div_o (ch_div[c+1])
		);
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:   if (accept) state_n = ST_CHECK;
			ST_CHECK:  state_n = out_rdy ? ST_FETCH : ST_IDLE;
			ST_FETCH:  if (last_s2) state_n = ST_SELECT;
			ST_SELECT: state_n = skip_div ? ST_PUT : ST_DIVIDE;
			ST_DIVIDE: if (div_cnt_q == DCNT_W'(SUM_W - 1)) state_n = ST_PUT;
			ST_PUT:    if (put_fire) state_n = ST_IDLE;
			default:   state_n = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		div_en   = 1'b0;
		put_fire = 1'b0;
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_FETCH:  issue    = (tap_q != TAP_W'(NTAPS + 1));
			ST_DIVIDE: div_en   = 1'b1;
			ST_PUT:    put_fire = !out_valid_q || out_ready;
			default:   in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// positions
	logic out_last;
	assign out_last = (out_col_q == w_m1) && (out_row_q == h_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q     <= '0;
			in_row_q     <= '0;
			in_slot_q    <= '0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			out_slot_q   <= '0;
			frame_full_q <= 1'b0;
		end else if (cfg_write) begin
			in_col_q     <= '0;
			in_row_q     <= '0;
			in_slot_q    <= '0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			out_slot_q   <= '0;
			frame_full_q <= 1'b0;
		end else begin
			if (store_px) begin
				if (in_col_q == w_m1) begin
					in_col_q <= '0;
					if (in_row_q == h_m1) begin
						in_row_q     <= '0;
						in_slot_q    <= '0;
						frame_full_q <= 1'b1;
					end else begin
						in_row_q  <= in_row_q + ROW_BITS'(1);
						in_slot_q <= (in_slot_q == SLOT_W'(SLOTS - 1)) ? '0
							: in_slot_q + SLOT_W'(1);
					end
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end
			if (put_fire) begin
				if (out_last) begin
					out_col_q    <= '0;
					out_row_q    <= '0;
					out_slot_q   <= '0;
					frame_full_q <= 1'b0;
				end else if (out_col_q == w_m1) begin
					out_col_q  <= '0;
					out_row_q  <= out_row_q + ROW_BITS'(1);
					out_slot_q <= (out_slot_q == SLOT_W'(SLOTS - 1)) ? '0
						: out_slot_q + SLOT_W'(1);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
		end
	end

	// fetch counters and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q     <= '0;
			dxi_q     <= '0;
			dyi_q     <= '0;
			valid_s1  <= 1'b0;
			center_s1 <= 1'b0;
			last_s1   <= 1'b0;
			valid_s2  <= 1'b0;
			center_s2 <= 1'b0;
			last_s2   <= 1'b0;
			div_cnt_q <= '0;
			use_div_q <= 1'b0;
		end else begin
			if (state_q == ST_CHECK) begin
				tap_q <= '0;
				dxi_q <= '0;
				dyi_q <= '0;
			end else if (issue) begin
				tap_q <= tap_q + TAP_W'(1);
				if (tap_q != '0) begin
					if (dyi_q == IDX_W'(2 * REACH - 1)) begin
						dyi_q <= '0;
						dxi_q <= dxi_q + IDX_W'(1);
					end else begin
						dyi_q <= dyi_q + IDX_W'(1);
					end
				end
			end
			valid_s1  <= issue;
			center_s1 <= issue && (tap_q == '0);
			last_s1   <= issue && (tap_q == TAP_W'(NTAPS));
			valid_s2  <= valid_s1;
			center_s2 <= center_s1;
			last_s2   <= last_s1;
			if (state_q == ST_SELECT) begin
				div_cnt_q <= '0;
				use_div_q <= !skip_div;
			end else if (div_en) begin
				div_cnt_q <= div_cnt_q + DCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '0;
			sum_q    <= '0;
			cnt_q    <= '0;
		end else if (state_q == ST_CHECK) begin
			center_q <= '0;
			sum_q    <= '0;
			cnt_q    <= '0;
		end else if (valid_s2) begin
			if (center_s2) begin
				center_q <= rdata_s2;
			end else if (|rdata_s2) begin
				for (int k = 0; k < 4; k++) begin
					sum_q[k] <= sum_q[k] + SUM_W'(rdata_s2[k*CHANNEL_BITS +: CHANNEL_BITS]);
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// result assembly and output register
	logic [3:0][31:0] res_ext;
	logic [31:0]      col_ext;
	out_req_t         res;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			res_ext[k] = use_div_q ? 32'(ch_quo[SUM_W][k][CHANNEL_BITS-1:0])
				: 32'(center_q[k*CHANNEL_BITS +: CHANNEL_BITS]);
		end
		col_ext        = 32'(out_col_q);
		res.out_red    = res_ext[0][PIX_BITS-1:0];
		res.out_green  = res_ext[1][PIX_BITS-1:0];
		res.out_blue   = res_ext[2][PIX_BITS-1:0];
		res.out_alpha  = res_ext[3][PIX_BITS-1:0];
		res.out_column = col_ext[OUT_COL_BITS-1:0];
		res.out_row    = out_row_q;
		res.frame_last = out_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (put_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (put_fire) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== hw/rtl/hfd_line_store.sv =====
// Line store of the hole fill dilation unit: one write port, one read port.
// Read data is registered. Depends on hfd_pkg only by convention.
module hfd_line_store #(
	parameter int DEPTH  = 24576,
	parameter int ADDR_W = 15,
	parameter int DATA_W = 64
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);
	import hfd_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/hfd_div_cell.sv =====
// One cell of the divider chain: a restoring step for four channel lanes.
// Depends on hfd_pkg; instantiated in a row by the top level.
module hfd_div_cell #(
	parameter int SUM_W = 21,
	parameter int CNT_W = 5
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [3:0][SUM_W-1:0] dvd_i,
	input  logic [3:0][SUM_W-1:0] quo_i,
	input  logic [3:0][CNT_W-1:0] rem_i,
	input  logic [CNT_W-1:0]      div_i,
	output logic [3:0][SUM_W-1:0] dvd_o,
	output logic [3:0][SUM_W-1:0] quo_o,
	output logic [3:0][CNT_W-1:0] rem_o,
	output logic [CNT_W-1:0]      div_o
);
	import hfd_pkg::*;

	logic [3:0][CNT_W:0]      trial;
	logic [3:0]               ge;
	logic [3:0][CNT_W:0]      diff;
	logic [3:0][CNT_W-1:0]    rem_n;
	logic [3:0][SUM_W-1:0]    quo_n;
	logic [3:0][SUM_W-1:0]    dvd_n;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			trial[l] = {rem_i[l], dvd_i[l][SUM_W-1]};
			ge[l]    = trial[l] >= {1'b0, div_i};
			diff[l]  = trial[l] - {1'b0, div_i};
			rem_n[l] = ge[l] ? diff[l][CNT_W-1:0] : trial[l][CNT_W-1:0];
			quo_n[l] = {quo_i[l][SUM_W-2:0], ge[l]};
			dvd_n[l] = {dvd_i[l][SUM_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_o <= dvd_n;
			quo_o <= quo_n;
			rem_o <= rem_n;
			div_o <= div_i;
		end
	end

endmodule

// ===== hw/rtl/hfd_checker.sv =====
// Port checker of the hole fill dilation unit, bound to the top level.
// Depends on hfd_pkg and hole_fill_dilation_unit_assert.svh.
`include "hole_fill_dilation_unit_assert.svh"

module hfd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input hfd_pkg::out_req_t out_data
);
	import hfd_pkg::*;

	// hold a stalled result
	`HFD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

	// busy right after a request is taken
	`HFD_ASSERT_NEXT(a_busy_after_req, clk, arst_n, in_valid && in_ready, !in_ready)

	// no result can appear in the cycle after a request is taken
	`HFD_ASSERT_NEXT(a_no_early_result, clk, arst_n, in_valid && in_ready, !$rose(out_valid))

endmodule

bind hole_fill_dilation_unit hfd_checker u_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for hole_fill_dilation_unit: raster frames of
// random RGBA pixels, holes and drain requests, predicted in the bench.
// Depends on hfd_pkg and the hole_fill_dilation_unit RTL.
`timescale 1ns / 100ps

module testbench;
	import hfd_pkg::*;

	localparam int MAX_W     = 4096;
	localparam int SLOTS     = 6;
	localparam int REACH     = 2;
	localparam int SETTLE    = 60;
	localparam int LIMIT     = 3000000;
	localparam int ITEM_GOAL = 1850;

	typedef logic [3:0][PIX_BITS-1:0] pix_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	in_req_t             in_data;
	logic                out_valid;
	logic                out_ready;
	out_req_t            out_data;
	logic                cfg_write;
	logic                cfg_index;
	logic [CFG_BITS-1:0] cfg_data;

	in_req_t  feed_q[$];
	out_req_t fill_expect_q[$];
	logic     in_taken;
	int       send_idle_pct;
	int       recv_stall_pct;
	bit       hold_req;
	int       hold_left;
	int       fails;
	int       cycles;
	int       items_sent;

	// predictor state
	pix_t                  line_mem [SLOTS*MAX_W];
	logic [IMG_W_BITS-1:0] width_reg;
	logic [ROW_BITS-1:0]   height_reg;
	int                    in_col, in_row, out_col, out_row;
	bit                    frame_done;

	hole_fill_dilation_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int eff_width();
		if (width_reg == 0) return 1;
		if (width_reg > MAX_W) return MAX_W;
		return int'(width_reg);
	endfunction

	function automatic int eff_height();
		return (height_reg == 0) ? 1 : int'(height_reg);
	endfunction

	function automatic pix_t fetch_px(int x, int y, int w, int h);
		int cx, cy;
		cx = (x < 0) ? 0 : ((x >= w) ? w - 1 : x);
		cy = (y < 0) ? 0 : ((y >= h) ? h - 1 : y);
		return line_mem[(cy % SLOTS) * MAX_W + cx];
	endfunction

	function automatic void restart_frame();
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
		frame_done = 0;
	endfunction

	function automatic void apply_cfg(logic idx, logic [CFG_BITS-1:0] val);
		if (idx == CFG_IMAGE_WIDTH)
			width_reg = val[IMG_W_BITS-1:0];
		else
			height_reg = val[ROW_BITS-1:0];
		restart_frame();
	endfunction

	function automatic bit result_due(int w, int h);
		int nr, nc;
		if (frame_done) return 1;
		nr = (out_row + REACH > h - 1) ? h - 1 : out_row + REACH;
		nc = (out_col + REACH > w - 1) ? w - 1 : out_col + REACH;
		if (in_row > nr) return 1;
		return (in_row == nr) && (in_col > nc);
	endfunction

	function automatic void predict_fill(in_req_t req);
		int          w, h, cnt;
		longint      sum [4];
		pix_t        px, nb, res;
		out_req_t    o;
		bit          last;
		w = eff_width();
		h = eff_height();
		if (req.operation == OP_PIXEL && !frame_done && in_col < w && in_row < h) begin
			line_mem[(in_row % SLOTS) * MAX_W + in_col] =
				{req.in_alpha, req.in_blue, req.in_green, req.in_red};
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
				if (in_row >= h) begin
					in_row = 0;
					frame_done = 1;
				end
			end
		end
		if (!result_due(w, h)) return;
		px = fetch_px(out_col, out_row, w, h);
		res = px;
		if (px == '0) begin
			cnt = 0;
			for (int k = 0; k < 4; k++) sum[k] = 0;
			for (int dx = -REACH; dx <= REACH; dx++) begin
				for (int dy = -REACH; dy <= REACH; dy++) begin
					if (dx != 0 && dy != 0) begin
						nb = fetch_px(out_col + dx, out_row + dy, w, h);
						if (nb != '0) begin
							for (int k = 0; k < 4; k++) sum[k] += nb[k];
							cnt++;
						end
					end
				end
			end
			if (cnt > 0)
				for (int k = 0; k < 4; k++)
					res[k] = PIX_BITS'((sum[k] + cnt / 2) / cnt);
		end
		last = (out_col == w - 1) && (out_row == h - 1);
		o.out_red    = res[0];
		o.out_green  = res[1];
		o.out_blue   = res[2];
		o.out_alpha  = res[3];
		o.out_column = out_col[OUT_COL_BITS-1:0];
		o.out_row    = out_row[ROW_BITS-1:0];
		o.frame_last = last;
		fill_expect_q.push_back(o);
		if (last) begin
			out_col = 0;
			out_row = 0;
			frame_done = 0;
		end else begin
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end
	endfunction

	task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			fails++;
		end
	endtask

	// monitor and predictor update
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && in_ready;
			if (cfg_write) apply_cfg(cfg_index, cfg_data);
			if (in_valid && in_ready) predict_fill(in_data);
			if (out_valid && out_ready) begin
				if (fill_expect_q.size() == 0) begin
					$error("unexpected result at column %0d row %0d",
						out_data.out_column, out_data.out_row);
					fails++;
				end else begin
					out_req_t e;
					e = fill_expect_q.pop_front();
					check_field("out_red", e.out_red, out_data.out_red);
					check_field("out_green", e.out_green, out_data.out_green);
					check_field("out_blue", e.out_blue, out_data.out_blue);
					check_field("out_alpha", e.out_alpha, out_data.out_alpha);
					check_field("out_column", e.out_column, out_data.out_column);
					check_field("out_row", e.out_row, out_data.out_row);
					check_field("frame_last", e.frame_last, out_data.frame_last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// request driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else if (!in_valid || in_taken) begin
			if (feed_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_data  <= feed_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (hold_req) begin
				hold_req = 0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic logic [PIX_BITS-1:0] rand_chan();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return 16'(1) << $urandom_range(15);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_pixel(logic [PIX_BITS-1:0] r, logic [PIX_BITS-1:0] g,
			logic [PIX_BITS-1:0] b, logic [PIX_BITS-1:0] a);
		in_req_t q;
		q.operation = OP_PIXEL;
		q.in_red    = r;
		q.in_green  = g;
		q.in_blue   = b;
		q.in_alpha  = a;
		feed_q.push_back(q);
		items_sent++;
	endtask

	task automatic push_drain();
		in_req_t q;
		q = in_req_t'($bits(in_req_t)'({$urandom, $urandom, $urandom}));
		q.operation = OP_DRAIN;
		feed_q.push_back(q);
		items_sent++;
	endtask

	task automatic push_random(int hole_pct);
		if ($urandom_range(99) < 8)
			push_drain();
		else if ($urandom_range(99) < hole_pct)
			push_pixel('0, '0, '0, '0);
		else
			push_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan());
	endtask

	task automatic wait_drained();
		while (feed_q.size() > 0 || in_valid || fill_expect_q.size() > 0)
			@(posedge clk);
	endtask

	task automatic set_size(int w, int h, int mode);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data  <= CFG_BITS'(w);
		@(negedge clk);
		cfg_index <= CFG_IMAGE_HEIGHT;
		cfg_data  <= CFG_BITS'(h);
		@(negedge clk);
		cfg_write <= 1'b0;
		case (mode % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
			default: begin send_idle_pct = 25; recv_stall_pct = 25; end
		endcase
	endtask

	task automatic push_flush(int w);
		repeat (2 * w + 8) push_drain();
	endtask

	initial begin
		int w, h, phase;
		in_valid       = 1'b0;
		in_data        = '0;
		out_ready      = 1'b0;
		cfg_write      = 1'b0;
		cfg_index      = CFG_IMAGE_WIDTH;
		cfg_data       = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 0;
		fails          = 0;
		cycles         = 0;
		items_sent     = 0;
		width_reg      = IMAGE_WIDTH_RESET;
		height_reg     = IMAGE_HEIGHT_RESET;
		restart_frame();
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: 4x4 frame with holes, full-scale and single-channel pixels
		set_size(4, 4, 0);
		push_pixel('1, '1, '1, '1);
		push_pixel('0, '0, '0, '0);
		push_pixel(16'h0001, '0, '0, '0);
		push_pixel('0, '0, '0, 16'h8000);
		push_pixel('0, '0, '0, '0);
		push_drain();
		push_pixel('0, 16'hFFFF, '0, '0);
		push_pixel('0, '0, 16'h1234, '0);
		push_pixel('0, '0, '0, '0);
		push_pixel('1, '1, '1, '1);
		push_pixel('0, '0, '0, '0);
		push_pixel('0, '0, '0, '0);
		push_pixel('0, '0, '0, '0);
		push_pixel(16'h0003, 16'h0001, '0, '0);
		push_pixel('0, '0, '0, '0);
		push_pixel('0, '0, '0, '0);
		push_pixel('0, '0, '0, '0);
		push_pixel('0, '0, '0, '0);
		// data after frame end, then drains to flush
		push_pixel('1, '0, '1, '0);
		push_flush(4);

		// all-empty frame stays empty
		set_size(3, 2, 1);
		repeat (6) push_pixel('0, '0, '0, '0);
		push_flush(3);

		// zero sizes act as one
		set_size(0, 0, 2);
		repeat (4) begin
			push_random(40);
			push_drain();
		end

		// oversize width, partial frame cut by a register write
		set_size(8191, 2, 3);
		repeat (120) push_random(40);
		set_size(4096, 1, 0);
		repeat (120) push_random(40);
		set_size(5, 65535, 1);
		repeat (60) push_random(40);
		set_size(1, 7, 2);
		repeat (7) push_random(50);
		push_flush(1);

		// pressure: long receiver hold-off, then a pause until drained
		set_size(12, 6, 0);
		hold_req = 1;
		repeat (36) push_random(40);
		wait_drained();
		repeat (36) push_random(40);
		push_flush(12);

		phase = 0;
		while (items_sent < ITEM_GOAL) begin
			case ($urandom_range(5))
				0: w = 1;
				1: w = $urandom_range(2, 3);
				default: w = $urandom_range(4, 12);
			endcase
			h = ($urandom_range(5) == 0) ? 1 : $urandom_range(2, 8);
			set_size(w, h, phase);
			phase++;
			repeat ($urandom_range(1, 3)) begin
				repeat (w * h) push_random($urandom_range(10, 70));
				if ($urandom_range(3) == 0)
					repeat ($urandom_range(1, 3)) push_random(30);
				push_flush(w);
			end
			// sometimes leave a frame unfinished before the next write
			if ($urandom_range(4) == 0)
				repeat ($urandom_range(1, w * h)) push_random(40);
		end

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
